// ===== rtl/iepm_pkg.sv =====
// Shared types and constants of the I2C EEPROM page master.
package iepm_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_SRST  = 2'd3;

   localparam logic [1:0] CSR_PAGE_SIZE_LOG2    = 2'd0;
   localparam logic [1:0] CSR_SLAVE_SELECT      = 2'd1;
   localparam logic [1:0] CSR_HALF_PERIOD_TICKS = 2'd2;
   localparam logic [1:0] CSR_WRITE_CYCLE_TICKS = 2'd3;

   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_START_A = 5'd1;
   localparam logic [4:0] PH_DEV_A   = 5'd2;
   localparam logic [4:0] PH_ADDR_HI = 5'd3;
   localparam logic [4:0] PH_ADDR_LO = 5'd4;
   localparam logic [4:0] PH_DATA    = 5'd5;
   localparam logic [4:0] PH_GAP     = 5'd6;
   localparam logic [4:0] PH_START_B = 5'd7;
   localparam logic [4:0] PH_DEV_B   = 5'd8;
   localparam logic [4:0] PH_RECV    = 5'd9;
   localparam logic [4:0] PH_STOP    = 5'd10;
   localparam logic [4:0] PH_WCYC    = 5'd11;
   localparam logic [4:0] PH_SRST    = 5'd12;

   localparam logic [7:0]  DEV_BASE        = 8'hA0;
   localparam logic [9:0]  BLOCK_LIMIT     = 10'h1FF;
   localparam logic [2:0]  RESET_PAGE_LOG2 = 3'd7;
   localparam logic [19:0] RESET_WCYC      = 20'd1250;
   localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;
   localparam logic [3:0]  SRST_PULSES     = 4'd9;

   typedef struct packed {
      logic [2:0]  page_size_log2;
      logic [1:0]  slave_select;
      logic [7:0]  half_period_ticks;
      logic [19:0] write_cycle_ticks;
   } cfg_type;

   typedef struct packed {
      logic       scl_low;
      logic       sda_low;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       data_request;
      logic       busy_res;
      logic       done_res;
   } result_type;

endpackage

// ===== rtl/iepm_csr.sv =====
// Configuration registers of the I2C EEPROM page master.
module iepm_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [19:0]          csr_write_data,
   output iepm_pkg::cfg_type    cfg
);

   iepm_pkg::cfg_type cfg_ff;
   iepm_pkg::cfg_type cfg_in;
   logic              wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_index)
            iepm_pkg::CSR_PAGE_SIZE_LOG2:    cfg_in.page_size_log2    = csr_write_data[2:0];
            iepm_pkg::CSR_SLAVE_SELECT:      cfg_in.slave_select      = csr_write_data[1:0];
            iepm_pkg::CSR_HALF_PERIOD_TICKS: cfg_in.half_period_ticks = csr_write_data[7:0];
            iepm_pkg::CSR_WRITE_CYCLE_TICKS: cfg_in.write_cycle_ticks = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_size_log2    <= iepm_pkg::RESET_PAGE_LOG2;
         cfg_ff.slave_select      <= 2'd0;
         cfg_ff.half_period_ticks <= 8'd0;
         cfg_ff.write_cycle_ticks <= iepm_pkg::RESET_WCYC;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/iepm_seq.sv =====
// Bit-level bus sequencer: state registers and the per-tick next-state logic.
module iepm_seq #(
   parameter int MAX_PAGE_BYTES = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  iepm_pkg::cfg_type       cfg,
   input  logic [1:0]              opcode,
   input  logic [9:0]              page,
   input  logic [7:0]              byte_count,
   input  logic [7:0]              write_data,
   input  logic                    scl_in,
   input  logic                    sda_in,
   output iepm_pkg::result_type    result
);

   localparam logic [8:0] MAX_BYTES = 9'(MAX_PAGE_BYTES);

   logic [4:0]  phase_ff, phase_in;
   logic [1:0]  quarter_ff, quarter_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  shift_ff, shift_in;
   logic [19:0] wait_ff, wait_in;
   logic [9:0]  page_ff, page_in;
   logic        is_read_ff, is_read_in;
   logic        scl_drive_ff, scl_drive_in;
   logic        sda_drive_ff, sda_drive_in;

   logic [7:0]  dev_byte;
   logic [8:0]  count_sat;
   logic        send;
   logic [3:0]  hi_shift;
   logic [9:0]  addr_hi;
   logic [9:0]  addr_lo;

   always_comb begin
      dev_byte = iepm_pkg::DEV_BASE | {5'd0, cfg.slave_select, 1'b0}
                 | {4'd0, (page_ff > iepm_pkg::BLOCK_LIMIT), 3'd0};
      count_sat = ({1'b0, byte_count} > MAX_BYTES) ? MAX_BYTES : {1'b0, byte_count};
      send = phase_ff inside {iepm_pkg::PH_DEV_A, iepm_pkg::PH_ADDR_HI,
                              iepm_pkg::PH_ADDR_LO, iepm_pkg::PH_DATA, iepm_pkg::PH_DEV_B};
      hi_shift = 4'd8 - {1'b0, cfg.page_size_log2};
      addr_hi  = page_ff >> hi_shift;
      addr_lo  = page_ff << cfg.page_size_log2;

      phase_in      = phase_ff;
      quarter_in    = quarter_ff;
      bit_count_in  = bit_count_ff;
      bytes_left_in = bytes_left_ff;
      shift_in      = shift_ff;
      wait_in       = wait_ff;
      page_in       = page_ff;
      is_read_in    = is_read_ff;
      scl_drive_in  = scl_drive_ff;
      sda_drive_in  = sda_drive_ff;
      result        = '0;

      if (step) begin
         if (phase_ff == iepm_pkg::PH_IDLE) begin
            if (opcode == iepm_pkg::OP_READ || opcode == iepm_pkg::OP_WRITE) begin
               is_read_in    = (opcode == iepm_pkg::OP_READ);
               bytes_left_in = count_sat[7:0];
               if (opcode == iepm_pkg::OP_READ && count_sat == 9'd0) bytes_left_in = 8'd1;
               page_in      = page;
               phase_in     = iepm_pkg::PH_START_A;
               shift_in     = 8'd0;
               bit_count_in = 4'd0;
               quarter_in   = 2'd0;
               wait_in      = 20'd0;
            end else if (opcode == iepm_pkg::OP_SRST) begin
               phase_in     = iepm_pkg::PH_SRST;
               shift_in     = 8'd0;
               bit_count_in = 4'd0;
               quarter_in   = 2'd0;
               wait_in      = 20'd0;
            end
         end else if (wait_ff != 20'd0) begin
            wait_in = wait_ff - 20'd1;
         end else if (phase_ff == iepm_pkg::PH_GAP) begin
            phase_in     = iepm_pkg::PH_START_B;
            shift_in     = 8'd0;
            bit_count_in = 4'd0;
            quarter_in   = 2'd0;
         end else if (phase_ff == iepm_pkg::PH_WCYC) begin
            phase_in        = iepm_pkg::PH_IDLE;
            quarter_in      = 2'd0;
            bit_count_in    = 4'd0;
            wait_in         = 20'd0;
            result.done_res = 1'b1;
         end else if (quarter_ff == 2'd2 && !scl_in && phase_ff != iepm_pkg::PH_SRST) begin
            // clock stretching: hold until SCL is seen high
            phase_in = phase_ff;
         end else begin
            wait_in    = {12'd0, cfg.half_period_ticks};
            quarter_in = quarter_ff + 2'd1;
            case (phase_ff)
               iepm_pkg::PH_SRST: begin
                  case (quarter_ff)
                     2'd0: sda_drive_in = 1'b1;
                     2'd1: scl_drive_in = 1'b1;
                     2'd2: sda_drive_in = 1'b0;
                     default: begin
                        scl_drive_in = 1'b0;
                        bit_count_in = bit_count_ff + 4'd1;
                        if (bit_count_in >= iepm_pkg::SRST_PULSES) begin
                           phase_in        = iepm_pkg::PH_IDLE;
                           quarter_in      = 2'd0;
                           bit_count_in    = 4'd0;
                           wait_in         = 20'd0;
                           result.done_res = 1'b1;
                        end
                     end
                  endcase
               end
               iepm_pkg::PH_START_A, iepm_pkg::PH_START_B: begin
                  case (quarter_ff)
                     2'd0: sda_drive_in = 1'b0;
                     2'd1: scl_drive_in = 1'b0;
                     2'd2: sda_drive_in = 1'b1;
                     default: begin
                        scl_drive_in = 1'b1;
                        bit_count_in = 4'd0;
                        quarter_in   = 2'd0;
                        if (phase_ff == iepm_pkg::PH_START_A) begin
                           phase_in = iepm_pkg::PH_DEV_A;
                           shift_in = dev_byte;
                        end else begin
                           phase_in = iepm_pkg::PH_DEV_B;
                           shift_in = dev_byte | 8'h01;
                        end
                     end
                  endcase
               end
               iepm_pkg::PH_STOP: begin
                  case (quarter_ff)
                     2'd0: sda_drive_in = 1'b1;
                     2'd1: scl_drive_in = 1'b0;
                     2'd2: sda_drive_in = sda_drive_ff;
                     default: begin
                        sda_drive_in = 1'b0;
                        bit_count_in = 4'd0;
                        quarter_in   = 2'd0;
                        if (is_read_ff) begin
                           phase_in        = iepm_pkg::PH_IDLE;
                           wait_in         = 20'd0;
                           result.done_res = 1'b1;
                        end else begin
                           phase_in = iepm_pkg::PH_WCYC;
                           shift_in = 8'd0;
                           wait_in  = cfg.write_cycle_ticks;
                        end
                     end
                  endcase
               end
               default: begin
                  case (quarter_ff)
                     2'd0: begin
                        if (bit_count_ff < iepm_pkg::BITS_PER_BYTE)
                           sda_drive_in = send ? ~shift_ff[7] : 1'b0;
                        else
                           sda_drive_in = send ? 1'b0 : (bytes_left_ff > 8'd1);
                     end
                     2'd1: scl_drive_in = 1'b0;
                     2'd2: begin
                        if (!send && bit_count_ff < iepm_pkg::BITS_PER_BYTE)
                           shift_in = {shift_ff[6:0], sda_in};
                     end
                     default: begin
                        scl_drive_in = 1'b1;
                        if (bit_count_ff < iepm_pkg::BITS_PER_BYTE) begin
                           if (send) shift_in = {shift_ff[6:0], 1'b0};
                           bit_count_in = bit_count_ff + 4'd1;
                        end else begin
                           bit_count_in = 4'd0;
                           quarter_in   = 2'd0;
                           if (send) begin
                              case (phase_ff)
                                 iepm_pkg::PH_DEV_A: begin
                                    phase_in = iepm_pkg::PH_ADDR_HI;
                                    shift_in = addr_hi[7:0];
                                 end
                                 iepm_pkg::PH_ADDR_HI: begin
                                    phase_in = iepm_pkg::PH_ADDR_LO;
                                    shift_in = addr_lo[7:0];
                                 end
                                 iepm_pkg::PH_ADDR_LO, iepm_pkg::PH_DATA: begin
                                    if (phase_ff == iepm_pkg::PH_DATA)
                                       bytes_left_in = bytes_left_ff - 8'd1;
                                    if (phase_ff == iepm_pkg::PH_ADDR_LO && is_read_ff) begin
                                       phase_in = iepm_pkg::PH_GAP;
                                       shift_in = 8'd0;
                                       wait_in  = cfg.write_cycle_ticks;
                                    end else if (bytes_left_in != 8'd0) begin
                                       phase_in            = iepm_pkg::PH_DATA;
                                       shift_in            = write_data;
                                       result.data_request = 1'b1;
                                    end else begin
                                       phase_in = iepm_pkg::PH_STOP;
                                       shift_in = 8'd0;
                                    end
                                 end
                                 default: begin
                                    phase_in = iepm_pkg::PH_RECV;
                                    shift_in = 8'd0;
                                 end
                              endcase
                           end else begin
                              result.read_data  = shift_ff;
                              result.read_valid = 1'b1;
                              result.read_last  = (bytes_left_ff <= 8'd1);
                              bytes_left_in = (bytes_left_ff != 8'd0) ?
                                              bytes_left_ff - 8'd1 : 8'd0;
                              shift_in = 8'd0;
                              phase_in = (bytes_left_in == 8'd0) ?
                                         iepm_pkg::PH_STOP : iepm_pkg::PH_RECV;
                           end
                        end
                     end
                  endcase
               end
            endcase
         end
      end

      result.scl_low  = scl_drive_in;
      result.sda_low  = sda_drive_in;
      result.busy_res = (phase_in != iepm_pkg::PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= iepm_pkg::PH_IDLE;
         quarter_ff    <= 2'd0;
         bit_count_ff  <= 4'd0;
         bytes_left_ff <= 8'd0;
         shift_ff      <= 8'd0;
         wait_ff       <= 20'd0;
         page_ff       <= 10'd0;
         is_read_ff    <= 1'b0;
         scl_drive_ff  <= 1'b0;
         sda_drive_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         quarter_ff    <= quarter_in;
         bit_count_ff  <= bit_count_in;
         bytes_left_ff <= bytes_left_in;
         shift_ff      <= shift_in;
         wait_ff       <= wait_in;
         page_ff       <= page_in;
         is_read_ff    <= is_read_in;
         scl_drive_ff  <= scl_drive_in;
         sda_drive_ff  <= sda_drive_in;
      end
   end

endmodule

// ===== rtl/i2c_eeprom_page_master.sv =====
// Top level of the I2C EEPROM page master: handshakes and result register.
//
// Each req_ transaction is one timing tick of an open-drain I2C master that reads
// or writes one page of a paged EEPROM. opcode 1 starts a page read, 2 a page
// write, 3 a nine-pulse bus reset, 0 only advances time; commands are ignored
// while busy. Each tick yields exactly one rsp_ transaction carrying the SCL/SDA
// pull-down drives, a read byte with read_valid/read_last, data_request (write_data
// of that tick was consumed), busy and done flags.
// The result of a tick is registered and presented in the cycle after the req_
// transaction is accepted. Throughput: one tick per cycle while no result is held;
// the sequencer state and the result register both update in the accepting cycle.
// The csr_ channel writes page size, chip select, SCL half period and write-cycle
// wait; it is always ready; the user must use it only while the sequencer is idle
// (unenforced). Reset clears the sequencer to idle with both lines released and
// loads the configuration defaults. When rsp_ready is low the result is held and
// req_ready drops, so no tick is taken until the pending result is delivered.
module i2c_eeprom_page_master #(
   parameter int MAX_PAGE_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [9:0]  req_page,
   input  logic [7:0]  req_byte_count,
   input  logic [7:0]  req_write_data,
   input  logic        req_scl_in,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_low,
   output logic        rsp_sda_low,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_read_valid,
   output logic        rsp_read_last,
   output logic        rsp_data_request,
   output logic        rsp_busy_res,
   output logic        rsp_done_res
);

   iepm_pkg::cfg_type    cfg;
   iepm_pkg::result_type result;
   iepm_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 step;

   iepm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   iepm_seq #(
      .MAX_PAGE_BYTES (MAX_PAGE_BYTES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cfg        (cfg),
      .opcode     (req_opcode),
      .page       (req_page),
      .byte_count (req_byte_count),
      .write_data (req_write_data),
      .scl_in     (req_scl_in),
      .sda_in     (req_sda_in),
      .result     (result)
   );

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign step         = req_valid && req_ready;
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_low      = rsp_ff.scl_low;
   assign rsp_sda_low      = rsp_ff.sda_low;
   assign rsp_read_data    = rsp_ff.read_data;
   assign rsp_read_valid   = rsp_ff.read_valid;
   assign rsp_read_last    = rsp_ff.read_last;
   assign rsp_data_request = rsp_ff.data_request;
   assign rsp_busy_res     = rsp_ff.busy_res;
   assign rsp_done_res     = rsp_ff.done_res;

   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.read_last |-> rsp_ff.read_valid)
      else $error("read_last without read_valid");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("done while still busy");

   a_read_write_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.read_valid && rsp_ff.data_request))
      else $error("read byte and write request in one tick");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.read_valid |-> rsp_ff.busy_res)
      else $error("read byte delivered while idle");

endmodule

// ===== bench/tb_i2c_eeprom_page_master.sv =====
// Self-checking testbench for the I2C EEPROM page master: tick-level predictor and scoreboard.
module tb_i2c_eeprom_page_master;

   localparam int PAGE_BYTES = 128;

   typedef struct packed {
      logic [1:0] opcode;
      logic [9:0] page;
      logic [7:0] byte_count;
      logic [7:0] write_data;
      logic       scl_in;
      logic       sda_in;
   } tick_type;

   class eeprom_tick_scoreboard;
      iepm_pkg::cfg_type    cfg;
      logic [4:0]           phase;
      logic [1:0]           quarter;
      logic [3:0]           bit_cnt;
      logic [7:0]           bytes_left;
      logic [7:0]           shift_reg;
      logic [19:0]          wait_cnt;
      logic [9:0]           page_latch;
      logic                 is_read;
      logic                 scl_drive;
      logic                 sda_drive;
      iepm_pkg::result_type cur;
      iepm_pkg::result_type bus_results[$];
      int                   failures;

      function new();
         cfg.page_size_log2 = iepm_pkg::RESET_PAGE_LOG2;
         cfg.slave_select = '0;
         cfg.half_period_ticks = '0;
         cfg.write_cycle_ticks = iepm_pkg::RESET_WCYC;
         phase = iepm_pkg::PH_IDLE;
         quarter = '0;
         bit_cnt = '0;
         bytes_left = '0;
         shift_reg = '0;
         wait_cnt = '0;
         page_latch = '0;
         is_read = 1'b0;
         scl_drive = 1'b0;
         sda_drive = 1'b0;
         failures = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [19:0] data);
         case (index)
            iepm_pkg::CSR_PAGE_SIZE_LOG2:    cfg.page_size_log2 = data[2:0];
            iepm_pkg::CSR_SLAVE_SELECT:      cfg.slave_select = data[1:0];
            iepm_pkg::CSR_HALF_PERIOD_TICKS: cfg.half_period_ticks = data[7:0];
            iepm_pkg::CSR_WRITE_CYCLE_TICKS: cfg.write_cycle_ticks = data;
            default: ;
         endcase
      endfunction

      function void load_byte(logic [4:0] next_phase, logic [7:0] value);
         phase = next_phase;
         shift_reg = value;
         bit_cnt = '0;
         quarter = '0;
      endfunction

      function void end_sequence();
         phase = iepm_pkg::PH_IDLE;
         quarter = '0;
         bit_cnt = '0;
         wait_cnt = '0;
         cur.done_res = 1'b1;
      endfunction

      function logic [7:0] device_byte(logic rw);
         logic [7:0] dev;
         dev = iepm_pkg::DEV_BASE;
         dev[3] = page_latch > iepm_pkg::BLOCK_LIMIT;
         dev[2:1] = cfg.slave_select;
         dev[0] = rw;
         return dev;
      endfunction

      function void data_or_stop(tick_type t);
         if (bytes_left != 0) begin
            load_byte(iepm_pkg::PH_DATA, t.write_data);
            cur.data_request = 1'b1;
         end else begin
            load_byte(iepm_pkg::PH_STOP, '0);
         end
      endfunction

      function void byte_sent(tick_type t);
         logic [9:0] addr;
         case (phase)
            iepm_pkg::PH_DEV_A: begin
               addr = page_latch >> (4'd8 - {1'b0, cfg.page_size_log2});
               load_byte(iepm_pkg::PH_ADDR_HI, addr[7:0]);
            end
            iepm_pkg::PH_ADDR_HI: begin
               addr = page_latch << cfg.page_size_log2;
               load_byte(iepm_pkg::PH_ADDR_LO, addr[7:0]);
            end
            iepm_pkg::PH_ADDR_LO: begin
               if (is_read) begin
                  load_byte(iepm_pkg::PH_GAP, '0);
                  wait_cnt = cfg.write_cycle_ticks;
               end else begin
                  data_or_stop(t);
               end
            end
            iepm_pkg::PH_DATA: begin
               bytes_left = bytes_left - 8'd1;
               data_or_stop(t);
            end
            default: load_byte(iepm_pkg::PH_RECV, '0);
         endcase
      endfunction

      function void bus_action(tick_type t);
         logic [1:0] q;
         logic       send;
         q = quarter;
         send = phase == iepm_pkg::PH_DEV_A || phase == iepm_pkg::PH_ADDR_HI ||
                phase == iepm_pkg::PH_ADDR_LO || phase == iepm_pkg::PH_DATA ||
                phase == iepm_pkg::PH_DEV_B;
         if (phase == iepm_pkg::PH_GAP) begin
            load_byte(iepm_pkg::PH_START_B, '0);
            return;
         end
         if (phase == iepm_pkg::PH_WCYC) begin
            end_sequence();
            return;
         end
         // clock stretching: hold until SCL is seen high
         if (q == 2'd2 && !t.scl_in && phase != iepm_pkg::PH_SRST) return;
         wait_cnt = {12'd0, cfg.half_period_ticks};
         quarter = q + 2'd1;
         if (phase == iepm_pkg::PH_SRST) begin
            case (q)
               2'd0: sda_drive = 1'b1;
               2'd1: scl_drive = 1'b1;
               2'd2: sda_drive = 1'b0;
               default: begin
                  scl_drive = 1'b0;
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= iepm_pkg::SRST_PULSES) end_sequence();
               end
            endcase
            return;
         end
         if (phase == iepm_pkg::PH_START_A || phase == iepm_pkg::PH_START_B) begin
            case (q)
               2'd0: sda_drive = 1'b0;
               2'd1: scl_drive = 1'b0;
               2'd2: sda_drive = 1'b1;
               default: begin
                  scl_drive = 1'b1;
                  if (phase == iepm_pkg::PH_START_A)
                     load_byte(iepm_pkg::PH_DEV_A, device_byte(1'b0));
                  else
                     load_byte(iepm_pkg::PH_DEV_B, device_byte(1'b1));
               end
            endcase
            return;
         end
         if (phase == iepm_pkg::PH_STOP) begin
            case (q)
               2'd0: sda_drive = 1'b1;
               2'd1: scl_drive = 1'b0;
               2'd3: begin
                  sda_drive = 1'b0;
                  if (is_read) begin
                     end_sequence();
                  end else begin
                     load_byte(iepm_pkg::PH_WCYC, '0);
                     wait_cnt = cfg.write_cycle_ticks;
                  end
               end
               default: ;
            endcase
            return;
         end
         case (q)
            2'd0: begin
               if (bit_cnt < iepm_pkg::BITS_PER_BYTE) sda_drive = send ? ~shift_reg[7] : 1'b0;
               else sda_drive = send ? 1'b0 : (bytes_left > 8'd1);
            end
            2'd1: scl_drive = 1'b0;
            2'd2: begin
               if (!send && bit_cnt < iepm_pkg::BITS_PER_BYTE)
                  shift_reg = {shift_reg[6:0], t.sda_in};
            end
            default: begin
               scl_drive = 1'b1;
               if (bit_cnt < iepm_pkg::BITS_PER_BYTE) begin
                  if (send) shift_reg = {shift_reg[6:0], 1'b0};
                  bit_cnt = bit_cnt + 4'd1;
               end else if (send) begin
                  byte_sent(t);
               end else begin
                  cur.read_data = shift_reg;
                  cur.read_valid = 1'b1;
                  cur.read_last = bytes_left <= 8'd1;
                  if (bytes_left != 0) bytes_left = bytes_left - 8'd1;
                  if (bytes_left == 0) load_byte(iepm_pkg::PH_STOP, '0);
                  else load_byte(iepm_pkg::PH_RECV, '0);
               end
            end
         endcase
      endfunction

      function void take_tick(tick_type t);
         logic [7:0] n;
         cur = '0;
         if (phase == iepm_pkg::PH_IDLE) begin
            if (t.opcode == iepm_pkg::OP_READ || t.opcode == iepm_pkg::OP_WRITE) begin
               n = t.byte_count;
               if (n > PAGE_BYTES) n = 8'(PAGE_BYTES);
               is_read = t.opcode == iepm_pkg::OP_READ;
               if (is_read && n == 0) n = 8'd1;
               bytes_left = n;
               page_latch = t.page;
               load_byte(iepm_pkg::PH_START_A, '0);
               wait_cnt = '0;
            end else if (t.opcode == iepm_pkg::OP_SRST) begin
               load_byte(iepm_pkg::PH_SRST, '0);
               wait_cnt = '0;
            end
         end else if (wait_cnt != 0) begin
            wait_cnt = wait_cnt - 20'd1;
         end else begin
            bus_action(t);
         end
         cur.scl_low = scl_drive;
         cur.sda_low = sda_drive;
         cur.busy_res = phase != iepm_pkg::PH_IDLE;
         bus_results.push_back(cur);
      endfunction

      function void compare(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void check_result(iepm_pkg::result_type got);
         iepm_pkg::result_type want;
         if (bus_results.size() == 0) begin
            failures++;
            $display("%0t: unexpected transaction, expected none actual %h", $time, got);
            return;
         end
         want = bus_results.pop_front();
         compare("scl_low", want.scl_low, got.scl_low);
         compare("sda_low", want.sda_low, got.sda_low);
         compare("read_data", want.read_data, got.read_data);
         compare("read_valid", want.read_valid, got.read_valid);
         compare("read_last", want.read_last, got.read_last);
         compare("data_request", want.data_request, got.data_request);
         compare("busy_res", want.busy_res, got.busy_res);
         compare("done_res", want.done_res, got.done_res);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [19:0] csr_write_data;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [9:0]  req_page;
   logic [7:0]  req_byte_count;
   logic [7:0]  req_write_data;
   logic        req_scl_in;
   logic        req_sda_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_scl_low;
   logic        rsp_sda_low;
   logic [7:0]  rsp_read_data;
   logic        rsp_read_valid;
   logic        rsp_read_last;
   logic        rsp_data_request;
   logic        rsp_busy_res;
   logic        rsp_done_res;

   eeprom_tick_scoreboard sb;
   bit steady;
   int noise_pct;
   int stretch_pct;
   int ticks_sent;

   i2c_eeprom_page_master #(.MAX_PAGE_BYTES(PAGE_BYTES)) u_dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_page(req_page),
      .req_byte_count(req_byte_count),
      .req_write_data(req_write_data),
      .req_scl_in(req_scl_in),
      .req_sda_in(req_sda_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_scl_low(rsp_scl_low),
      .rsp_sda_low(rsp_sda_low),
      .rsp_read_data(rsp_read_data),
      .rsp_read_valid(rsp_read_valid),
      .rsp_read_last(rsp_read_last),
      .rsp_data_request(rsp_data_request),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res)
   );

   always #2 clock = ~clock;

   function automatic tick_type busy_tick();
      tick_type t;
      t.opcode = ($urandom_range(0, 99) < noise_pct) ? 2'($urandom_range(1, 3))
                                                      : iepm_pkg::OP_TICK;
      t.page = 10'($urandom);
      t.byte_count = 8'($urandom);
      t.write_data = 8'($urandom);
      t.scl_in = $urandom_range(0, 99) >= stretch_pct;
      t.sda_in = 1'($urandom);
      return t;
   endfunction

   task automatic send_tick(tick_type t);
      while (!steady && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= t.opcode;
      req_page <= t.page;
      req_byte_count <= t.byte_count;
      req_write_data <= t.write_data;
      req_scl_in <= t.scl_in;
      req_sda_in <= t.sda_in;
      do @(posedge clock); while (!req_ready);
      sb.take_tick(t);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic run_command(logic [1:0] op, logic [9:0] page, logic [7:0] count);
      tick_type t;
      t = busy_tick();
      t.opcode = op;
      t.page = page;
      t.byte_count = count;
      send_tick(t);
      while (sb.phase != iepm_pkg::PH_IDLE) send_tick(busy_tick());
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.bus_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [19:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, value);
      @(negedge clock);
   endtask

   task automatic apply_config(logic [2:0] k, logic [1:0] sel, logic [7:0] half,
                               logic [19:0] wcyc);
      logic [1:0]  regs [4];
      logic [19:0] values [4];
      regs[0] = iepm_pkg::CSR_PAGE_SIZE_LOG2;
      regs[1] = iepm_pkg::CSR_SLAVE_SELECT;
      regs[2] = iepm_pkg::CSR_HALF_PERIOD_TICKS;
      regs[3] = iepm_pkg::CSR_WRITE_CYCLE_TICKS;
      // junk in the unused upper bits must be ignored
      values[0] = {17'($urandom), k};
      values[1] = {18'($urandom), sel};
      values[2] = {12'($urandom), half};
      values[3] = wcyc;
      drain_results();
      for (int i = 0; i < 4; i++) write_csr(regs[i], values[i]);
      csr_valid <= 1'b0;
   endtask

   initial begin
      iepm_pkg::result_type got;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         rsp_ready <= steady || $urandom_range(0, 99) >= 29;
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.scl_low = rsp_scl_low;
            got.sda_low = rsp_sda_low;
            got.read_data = rsp_read_data;
            got.read_valid = rsp_read_valid;
            got.read_last = rsp_read_last;
            got.data_request = rsp_data_request;
            got.busy_res = rsp_busy_res;
            got.done_res = rsp_done_res;
            sb.check_result(got);
         end
      end
   end

   initial begin
      int      start;
      int      r;
      logic [1:0] op;
      logic [7:0] count;
      logic [7:0] half;
      sb = new();
      steady = 1'b0;
      noise_pct = 10;
      stretch_pct = 20;
      ticks_sent = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_opcode = iepm_pkg::OP_TICK;
      req_page = '0;
      req_byte_count = '0;
      req_write_data = '0;
      req_scl_in = 1'b1;
      req_sda_in = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration; only the write-cycle wait is shortened
      run_command(iepm_pkg::OP_TICK, 10'h000, 8'd0);
      run_command(iepm_pkg::OP_SRST, 10'h3FF, 8'd255);
      drain_results();
      write_csr(iepm_pkg::CSR_WRITE_CYCLE_TICKS, 20'd2);
      csr_valid <= 1'b0;
      run_command(iepm_pkg::OP_READ, 10'h3FF, 8'd0);

      apply_config(3'd5, 2'd3, 8'd0, 20'd1);
      run_command(iepm_pkg::OP_WRITE, 10'h1FF, 8'd2);
      run_command(iepm_pkg::OP_WRITE, 10'h000, 8'd0);
      stretch_pct = 60;
      run_command(iepm_pkg::OP_READ, 10'h200, 8'd1);
      stretch_pct = 20;

      apply_config(3'd0, 2'd1, 8'd1, 20'd0);
      run_command(iepm_pkg::OP_SRST, 10'h000, 8'd0);

      apply_config(3'd6, 2'd2, 8'd0, 20'hFFFFF);
      run_command(iepm_pkg::OP_SRST, 10'h155, 8'd1);
      run_command(iepm_pkg::OP_TICK, 10'h2AA, 8'd2);

      for (int p = 0; p < 2; p++) begin
         half = 8'($urandom_range(0, 1));
         apply_config(3'($urandom_range(0, 7)), 2'($urandom), half,
                      20'($urandom_range(0, 8)));
         steady = p == 1;
         start = ticks_sent;
         while (ticks_sent - start < 200) begin
            if ($urandom_range(0, 4) == 0) drain_results();
            r = $urandom_range(0, 99);
            op = r < 42 ? iepm_pkg::OP_READ : r < 82 ? iepm_pkg::OP_WRITE :
                 r < 92 ? iepm_pkg::OP_SRST : iepm_pkg::OP_TICK;
            count = 8'($urandom_range(0, 2));
            run_command(op, 10'($urandom), count);
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (4) @(negedge clock);
      if (sb.failures == 0) begin
         $display("i2c_eeprom_page_master verification clean");
      end else begin
         $display("i2c_eeprom_page_master verification failed");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("i2c_eeprom_page_master verification failed");
      $finish;
   end

endmodule
